// File: src/assert_macros.svh
// Assertion macros used by the draw engine controller (cfde_ctrl).
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define CFDE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("draw engine assertion failed");

// Checked on every rising clock edge, reset included.
`define CFDE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("draw engine assertion failed");

`endif

// File: src/cfde_pkg.sv
// Shared types and constants of the clipped framebuffer draw engine.
// No dependencies; used by the controller, the datapath and the top level.
package cfde_pkg;

  localparam int CW = 19;

  typedef enum logic [2:0] {
    MODE_CLEAR  = 3'd0,
    MODE_PIXEL  = 3'd1,
    MODE_SPAN   = 3'd2,
    MODE_RECT   = 3'd3,
    MODE_FRAME  = 3'd4,
    MODE_SPRITE = 3'd5,
    MODE_READ   = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    PH_TOP    = 2'd0,
    PH_BOTTOM = 2'd1,
    PH_LEFT   = 2'd2,
    PH_RIGHT  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_SETUP   = 3'd1,
    ST_EVAL    = 3'd2,
    ST_RUN     = 3'd3,
    ST_RD_WAIT = 3'd4,
    ST_DONE    = 3'd5
  } state_e;

  typedef struct packed {
    logic   load;
    logic   setup;
    logic   step;
    logic   we;
    logic   re;
    logic   capture;
    logic   load_out;
    phase_e phase;
  } dp_cmd_t;

  typedef struct packed {
    logic nonempty;
    logic span_end;
    logic rect_end;
    logic is_read;
    logic is_frame;
  } dp_sts_t;

endpackage

// File: src/cfde_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module cfde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/cfde_ctrl.sv
// Controller state machine of the draw engine: sequences setup, pixel runs,
// frame phases, reads and the result register. Uses cfde_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cfde_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cfde_pkg::dp_cmd_t cmd_o,
  input  cfde_pkg::dp_sts_t sts_i
);
  import cfde_pkg::*;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic   out_valid_q, out_valid_d;
  logic   more_phases;

  assign more_phases = sts_i.is_frame && (phase_q != PH_RIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_TOP;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    cmd_o       = '0;
    cmd_o.phase = phase_q;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          phase_d    = PH_TOP;
          state_d    = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_EVAL;
      end
      ST_EVAL: begin
        if (sts_i.is_read) begin
          if (sts_i.nonempty) begin
            cmd_o.re = 1'b1;
            state_d  = ST_RD_WAIT;
          end else begin
            state_d = ST_DONE;
          end
        end else if (sts_i.nonempty) begin
          state_d = ST_RUN;
        end else if (more_phases) begin
          phase_d = phase_e'(phase_q + 2'd1);
          state_d = ST_SETUP;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_RUN: begin
        cmd_o.we   = 1'b1;
        cmd_o.step = 1'b1;
        if (sts_i.rect_end) begin
          if (more_phases) begin
            phase_d = phase_e'(phase_q + 2'd1);
            state_d = ST_SETUP;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_RD_WAIT: begin
        cmd_o.capture = 1'b1;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  `CFDE_ASSERT(a_accept_to_setup, in_valid_i && !in_stall_o |=> state_q == ST_SETUP)
  `CFDE_ASSERT(a_rd_wait_after_eval, state_q == ST_RD_WAIT |-> $past(state_q) == ST_EVAL)
  `CFDE_ASSERT(a_write_needs_clip, cmd_o.we |-> sts_i.nonempty && !sts_i.is_read)
  `CFDE_ASSERT(a_phase_only_frame, phase_q != PH_TOP && state_q != ST_IDLE |-> sts_i.is_frame)
  `CFDE_ASSERT(a_rect_end_at_span_end, state_q == ST_RUN && sts_i.rect_end |-> sts_i.span_end)

endmodule

// File: src/cfde_datapath.sv
// Datapath of the draw engine: command registers, clipping, row and column
// counters, pixel address and result registers. Uses cfde_pkg.
module cfde_datapath #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 200,
  localparam int AW  = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT),
  localparam int CLW = $clog2(SCREEN_WIDTH),
  localparam int RLW = $clog2(SCREEN_HEIGHT)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfde_pkg::dp_cmd_t  cmd_i,
  output cfde_pkg::dp_sts_t  sts_o,
  input  logic [2:0]         mode_i,
  input  logic signed [15:0] x_i,
  input  logic signed [15:0] y_i,
  input  logic signed [15:0] width_i,
  input  logic signed [15:0] height_i,
  input  logic [14:0]        offset_x_i,
  input  logic [14:0]        offset_y_i,
  input  logic [7:0]         color_i,
  output logic [AW-1:0]      addr_o,
  output logic [7:0]         wdata_o,
  output logic               we_o,
  output logic               re_o,
  input  logic [7:0]         rdata_i,
  output logic [7:0]         read_color_o
);
  import cfde_pkg::*;

  logic [2:0]         mode_q;
  logic signed [15:0] x_q, y_q, w_q, h_q;
  logic [14:0]        ox_q, oy_q;
  logic [7:0]         color_q;
  logic               nonempty_q;
  logic [CLW-1:0]     xs_q, xl_q, col_q;
  logic [RLW-1:0]     yl_q, row_q;
  logic [7:0]         res_q, out_color_q;

  logic signed [CW-1:0] xw, yw, ww, hw, oxw, oyw;
  logic signed [CW-1:0] px, py, pw, ph;
  logic signed [CW-1:0] xsum, ysum, xs_w, xe_w, ys_w, ye_w, xl_w, yl_w;
  logic                 sprite_hit, nonempty_w;

  assign xw  = CW'(x_q);
  assign yw  = CW'(y_q);
  assign ww  = CW'(w_q);
  assign hw  = CW'(h_q);
  assign oxw = CW'(ox_q);
  assign oyw = CW'(oy_q);
  assign sprite_hit = (oxw < ww) && (oyw < hw) && (color_q != 8'd0);

  always_comb begin
    px = xw;
    py = yw;
    pw = CW'(1);
    ph = CW'(1);
    case (mode_q)
      MODE_CLEAR: begin
        px = '0;
        py = '0;
        pw = CW'(SCREEN_WIDTH);
        ph = CW'(SCREEN_HEIGHT);
      end
      MODE_PIXEL, MODE_READ: begin
      end
      MODE_SPAN: begin
        pw = ww;
      end
      MODE_RECT: begin
        pw = ww;
        ph = hw;
      end
      MODE_FRAME: begin
        case (cmd_i.phase)
          PH_TOP: begin
            pw = ww;
          end
          PH_BOTTOM: begin
            py = yw + hw - CW'(1);
            pw = ww;
          end
          PH_LEFT: begin
            ph = hw;
          end
          PH_RIGHT: begin
            px = xw + ww - CW'(1);
            ph = hw;
          end
          default: begin
          end
        endcase
      end
      MODE_SPRITE: begin
        px = xw + oxw;
        py = yw + oyw;
        ph = sprite_hit ? CW'(1) : CW'(0);
      end
      default: begin
        ph = '0;
      end
    endcase
  end

  always_comb begin
    xsum = px + pw;
    ysum = py + ph;
    xs_w = (px < 0) ? '0 : px;
    ys_w = (py < 0) ? '0 : py;
    xe_w = (xsum > CW'(SCREEN_WIDTH)) ? CW'(SCREEN_WIDTH) : xsum;
    ye_w = (ysum > CW'(SCREEN_HEIGHT)) ? CW'(SCREEN_HEIGHT) : ysum;
    xl_w = xe_w - CW'(1);
    yl_w = ye_w - CW'(1);
    nonempty_w = (xe_w > xs_w) && (ye_w > ys_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonempty_q <= 1'b0;
    end else if (cmd_i.setup) begin
      nonempty_q <= nonempty_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_i;
      x_q     <= x_i;
      y_q     <= y_i;
      w_q     <= width_i;
      h_q     <= height_i;
      ox_q    <= offset_x_i;
      oy_q    <= offset_y_i;
      color_q <= color_i;
      res_q   <= 8'd0;
    end
    if (cmd_i.setup) begin
      xs_q  <= xs_w[CLW-1:0];
      xl_q  <= xl_w[CLW-1:0];
      col_q <= xs_w[CLW-1:0];
      row_q <= ys_w[RLW-1:0];
      yl_q  <= yl_w[RLW-1:0];
    end else if (cmd_i.step) begin
      if (col_q == xl_q) begin
        col_q <= xs_q;
        row_q <= row_q + RLW'(1);
      end else begin
        col_q <= col_q + CLW'(1);
      end
    end
    if (cmd_i.capture) begin
      res_q <= rdata_i;
    end
    if (cmd_i.load_out) begin
      out_color_q <= res_q;
    end
  end

  assign addr_o  = AW'(row_q) * AW'(SCREEN_WIDTH) + AW'(col_q);
  assign wdata_o = color_q;
  assign we_o    = cmd_i.we;
  assign re_o    = cmd_i.re;

  assign sts_o.nonempty = nonempty_q;
  assign sts_o.span_end = (col_q == xl_q);
  assign sts_o.rect_end = (col_q == xl_q) && (row_q == yl_q);
  assign sts_o.is_read  = (mode_q == MODE_READ);
  assign sts_o.is_frame = (mode_q == MODE_FRAME);

  assign read_color_o = out_color_q;

endmodule

// File: src/clipped_framebuffer_draw_engine_core.sv
// Top level of the clipped framebuffer draw engine.
// Instantiates cfde_ctrl, cfde_datapath and cfde_ram; uses cfde_pkg.
//
// Usage: one command beat on the input channel (mode, x, y, width, height,
// offset_x, offset_y, color) gives exactly one result beat (read_color) on
// the output channel. read_color carries the stored pixel for a read command
// and 0 for every other command or an off-screen read.
// Sequencing: each drawing pass starts with a setup and a clip check, then
// writes one pixel per cycle; the result register is loaded once the output
// register is free. Pixel, sprite and span commands run one pass over their
// visible pixels, a rectangle one pass over its visible area, a frame four
// passes, a clear one pass of SCREEN_WIDTH*SCREEN_HEIGHT pixels. A read goes
// through the registered memory port into the result register. The next
// command is taken once the controller is back in its idle state, so one
// command runs at a time.
// Reset clears control state only; the frame store is undefined until written,
// so software issues a clear first.
// A stalled result holds in the output register; the next command is still
// taken and runs, and it waits only to hand over its own result.
module clipped_framebuffer_draw_engine_core #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 200
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         mode_i,
  input  logic signed [15:0] x_i,
  input  logic signed [15:0] y_i,
  input  logic signed [15:0] width_i,
  input  logic signed [15:0] height_i,
  input  logic [14:0]        offset_x_i,
  input  logic [14:0]        offset_y_i,
  input  logic [7:0]         color_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         read_color_o
);
  import cfde_pkg::*;

  localparam int Depth = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW    = $clog2(Depth);

  dp_cmd_t       cmd;
  dp_sts_t       sts;
  logic [AW-1:0] addr;
  logic [7:0]    wdata, rdata;
  logic          we, re;

  cfde_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  cfde_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .mode_i       (mode_i),
    .x_i          (x_i),
    .y_i          (y_i),
    .width_i      (width_i),
    .height_i     (height_i),
    .offset_x_i   (offset_x_i),
    .offset_y_i   (offset_y_i),
    .color_i      (color_i),
    .addr_o       (addr),
    .wdata_o      (wdata),
    .we_o         (we),
    .re_o         (re),
    .rdata_i      (rdata),
    .read_color_o (read_color_o)
  );

  cfde_ram #(
    .WIDTH (8),
    .DEPTH (Depth)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

endmodule

// File: tb/tb_clipped_framebuffer_draw_engine_core.sv
// Self-checking testbench for clipped_framebuffer_draw_engine_core.
// Keeps a shadow copy of the frame store, predicts read_color per command beat
// and compares result beats in order; depends on cfde_pkg and the core only.
module tb_clipped_framebuffer_draw_engine_core;
  timeunit 1ns;
  timeprecision 1ps;

  import cfde_pkg::*;

  localparam int SCR_W = 320;
  localparam int SCR_H = 200;
  localparam int RANDOM_CMDS = 400;

  typedef struct {
    mode_e              mode;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] width;
    logic signed [15:0] height;
    logic [14:0]        offset_x;
    logic [14:0]        offset_y;
    logic [7:0]         color;
  } draw_cmd_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         mode_i = '0;
  logic signed [15:0] x_i = '0;
  logic signed [15:0] y_i = '0;
  logic signed [15:0] width_i = '0;
  logic signed [15:0] height_i = '0;
  logic [14:0]        offset_x_i = '0;
  logic [14:0]        offset_y_i = '0;
  logic [7:0]         color_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [7:0]         read_color_o;

  logic [7:0] fb_shadow [SCR_W*SCR_H];
  draw_cmd_t  pending_cmds [$];
  logic [7:0] expected_colors [$];

  draw_cmd_t  next_cmd;
  draw_cmd_t  seen_cmd;
  logic [7:0] want_color;
  logic       in_taken = 1'b0;
  logic       out_taken = 1'b0;
  bit         calm_in = 1'b0;
  bit         calm_out = 1'b0;
  bit         hold_done = 1'b0;
  int         in_gap = 0;
  int         out_wait = 0;
  int         hold_left = 0;
  int         results_seen = 0;
  int         mismatches = 0;

  clipped_framebuffer_draw_engine_core #(
    .SCREEN_WIDTH (SCR_W),
    .SCREEN_HEIGHT(SCR_H)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .x_i         (x_i),
    .y_i         (y_i),
    .width_i     (width_i),
    .height_i    (height_i),
    .offset_x_i  (offset_x_i),
    .offset_y_i  (offset_y_i),
    .color_i     (color_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_color_o(read_color_o)
  );

  function automatic void plot_pixel(int px, int py, logic [7:0] col);
    if (px >= 0 && px < SCR_W && py >= 0 && py < SCR_H) begin
      fb_shadow[py*SCR_W + px] = col;
    end
  endfunction

  function automatic void paint_span(int sx, int sy, int sw, logic [7:0] col);
    int stop;
    if (sy < 0 || sy >= SCR_H) return;
    if (sx < 0) begin
      sw = sw + sx;
      sx = 0;
    end
    stop = sx + sw;
    if (stop > SCR_W) stop = SCR_W;
    for (int i = sx; i < stop; i++) fb_shadow[sy*SCR_W + i] = col;
  endfunction

  function automatic logic [7:0] run_command(draw_cmd_t c);
    int         x;
    int         y;
    int         w;
    int         h;
    int         ox;
    int         oy;
    int         lo;
    int         hi;
    logic [7:0] rd;
    x = c.x;
    y = c.y;
    w = c.width;
    h = c.height;
    ox = c.offset_x;
    oy = c.offset_y;
    rd = '0;
    case (c.mode)
      MODE_CLEAR: begin
        for (int i = 0; i < SCR_W*SCR_H; i++) fb_shadow[i] = c.color;
      end
      MODE_PIXEL: plot_pixel(x, y, c.color);
      MODE_SPAN: paint_span(x, y, w, c.color);
      MODE_RECT, MODE_FRAME: begin
        if (c.mode == MODE_FRAME) begin
          paint_span(x, y, w, c.color);
          paint_span(x, y + h - 1, w, c.color);
        end
        lo = (y < 0) ? -y : 0;
        hi = SCR_H - y;
        if (hi > h) hi = h;
        for (int j = lo; j < hi; j++) begin
          if (c.mode == MODE_RECT) begin
            paint_span(x, y + j, w, c.color);
          end else begin
            plot_pixel(x, y + j, c.color);
            plot_pixel(x + w - 1, y + j, c.color);
          end
        end
      end
      MODE_SPRITE: begin
        if (ox < w && oy < h && c.color != 8'd0) plot_pixel(x + ox, y + oy, c.color);
      end
      MODE_READ: begin
        if (x >= 0 && x < SCR_W && y >= 0 && y < SCR_H) rd = fb_shadow[y*SCR_W + x];
      end
      default: rd = '0;
    endcase
    return rd;
  endfunction

  function automatic void queue_cmd(mode_e m, int x, int y, int w, int h, int ox, int oy,
                                    int col);
    draw_cmd_t c;
    c.mode = m;
    c.x = 16'(x);
    c.y = 16'(y);
    c.width = 16'(w);
    c.height = 16'(h);
    c.offset_x = 15'(ox);
    c.offset_y = 15'(oy);
    c.color = 8'(col);
    pending_cmds.push_back(c);
  endfunction

  function automatic int near(int ctr, int spread);
    if ($urandom_range(0, 9) == 0) return $urandom;
    return ctr + $urandom_range(0, 2*spread) - spread;
  endfunction

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #48000000;
    $display("TEST FAILED");
    $finish;
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (in_valid_i) begin
        if ($urandom_range(0, 29) == 0) calm_in = !calm_in;
        in_gap = calm_in ? 0 : $urandom_range(0, 16);
      end
      if (in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap--;
      end else if (pending_cmds.size() > 0) begin
        next_cmd = pending_cmds.pop_front();
        mode_i <= next_cmd.mode;
        x_i <= next_cmd.x;
        y_i <= next_cmd.y;
        width_i <= next_cmd.width;
        height_i <= next_cmd.height;
        offset_x_i <= next_cmd.offset_x;
        offset_y_i <= next_cmd.offset_y;
        color_i <= next_cmd.color;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Hold off the result side once for a long stretch so the core backs up.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && results_seen >= 120) begin
        hold_left = 600;
        hold_done = 1'b1;
      end
      if (out_taken) begin
        if ($urandom_range(0, 29) == 0) calm_out = !calm_out;
        out_wait = calm_out ? 0 : $urandom_range(0, 16);
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (out_wait > 0) begin
        out_stall_i <= 1'b1;
        out_wait--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    out_taken <= rst_ni && out_valid_o && !out_stall_i;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_colors.size() == 0) begin
        if (mismatches < 10) begin
          $display("%0t: result beat %0h with no command outstanding", $time, read_color_o);
        end
        mismatches++;
      end else begin
        want_color = expected_colors.pop_front();
        if (read_color_o !== want_color) begin
          if (mismatches < 10) begin
            $display("%0t: read_color expected %0h got %0h", $time, want_color, read_color_o);
          end
          mismatches++;
        end
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      seen_cmd.mode = mode_e'(mode_i);
      seen_cmd.x = x_i;
      seen_cmd.y = y_i;
      seen_cmd.width = width_i;
      seen_cmd.height = height_i;
      seen_cmd.offset_x = offset_x_i;
      seen_cmd.offset_y = offset_y_i;
      seen_cmd.color = color_i;
      expected_colors.push_back(run_command(seen_cmd));
    end
  end

  initial begin
    int fx;
    int fy;
    int pick;
    int col;
    int w;
    int h;
    int ox;
    int oy;
    int clears_left;
    bit wide;
    fx = 160;
    fy = 100;
    clears_left = 2;
    for (int i = 0; i < SCR_W*SCR_H; i++) fb_shadow[i] = '0;

    queue_cmd(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 8'hA5);
    queue_cmd(MODE_READ, SCR_W - 1, SCR_H - 1, 0, 0, 0, 0, 0);
    queue_cmd(MODE_RECT, -10, -10, SCR_W + 20, SCR_H + 20, 0, 0, 8'h33);
    queue_cmd(MODE_RECT, 5, 5, 10, 0, 0, 0, 8'h44);
    queue_cmd(MODE_RECT, 5, 5, 10, -32768, 0, 0, 8'h45);
    queue_cmd(MODE_FRAME, 0, 0, SCR_W, SCR_H, 0, 0, 8'h57);
    queue_cmd(MODE_FRAME, 10, 20, 0, 5, 0, 0, 8'h55);
    queue_cmd(MODE_FRAME, 30, 50, 20, 0, 0, 0, 8'h56);
    queue_cmd(MODE_PIXEL, 0, 0, 0, 0, 0, 0, 8'hFF);
    queue_cmd(MODE_PIXEL, SCR_W - 1, SCR_H - 1, 0, 0, 0, 0, 8'h01);
    queue_cmd(MODE_PIXEL, -32768, 32767, 0, 0, 0, 0, 8'h77);
    queue_cmd(MODE_SPAN, -5, 3, 10, 0, 0, 0, 8'h11);
    queue_cmd(MODE_SPAN, SCR_W - 5, 4, 32767, 0, 0, 0, 8'h12);
    queue_cmd(MODE_SPAN, -32768, 5, -32768, 0, 0, 0, 8'h13);
    queue_cmd(MODE_SPAN, 100, -1, 50, 0, 0, 0, 8'h14);
    queue_cmd(MODE_SPRITE, -32000, -32000, 32767, 32767, 32010, 32005, 8'h78);
    queue_cmd(MODE_SPRITE, 200, 100, 4, 4, 1, 1, 8'h00);
    queue_cmd(MODE_SPRITE, 200, 101, 4, 4, 4, 0, 8'h88);
    queue_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0);
    queue_cmd(MODE_READ, SCR_W - 1, SCR_H - 1, 0, 0, 0, 0, 0);
    queue_cmd(MODE_READ, -1, 0, 0, 0, 0, 0, 0);
    queue_cmd(MODE_READ, 0, SCR_H, 0, 0, 0, 0, 0);
    queue_cmd(MODE_READ, 2, 3, 0, 0, 0, 0, 0);
    queue_cmd(MODE_READ, SCR_W - 1, 4, 0, 0, 0, 0, 0);
    queue_cmd(MODE_READ, 10, 5, 0, 0, 0, 0, 0);
    queue_cmd(MODE_READ, 9, 22, 0, 0, 0, 0, 0);
    queue_cmd(MODE_READ, 40, 49, 0, 0, 0, 0, 0);

    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if ($urandom_range(0, 39) == 0) begin
        fx = $urandom_range(0, SCR_W - 1);
        fy = $urandom_range(0, SCR_H - 1);
      end
      pick = $urandom_range(0, 99);
      wide = ($urandom_range(0, 9) == 0);
      col = $urandom_range(0, 255);
      if (clears_left > 0 && $urandom_range(0, 149) == 0) begin
        queue_cmd(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, col);
        clears_left--;
      end else if (pick < 35) begin
        queue_cmd(MODE_READ, near(fx, 24), near(fy, 24), $urandom, $urandom, $urandom,
                  $urandom, col);
      end else if (pick < 45) begin
        queue_cmd(MODE_PIXEL, near(fx, 24), near(fy, 24), $urandom, $urandom, $urandom,
                  $urandom, col);
      end else if (pick < 60) begin
        w = wide ? $urandom : $urandom_range(0, 72) - 8;
        queue_cmd(MODE_SPAN, near(fx - 20, 24), near(fy, 24), w, $urandom, $urandom,
                  $urandom, col);
      end else if (pick < 70) begin
        w = $urandom_range(0, 48) - 8;
        h = $urandom_range(0, 48) - 8;
        queue_cmd(MODE_RECT, near(fx - 16, 24), near(fy - 16, 24), w, h, $urandom,
                  $urandom, col);
      end else if (pick < 82) begin
        w = wide ? $urandom : $urandom_range(0, 48) - 8;
        h = wide ? $urandom : $urandom_range(0, 48) - 8;
        queue_cmd(MODE_FRAME, near(fx - 16, 24), near(fy - 16, 24), w, h, $urandom,
                  $urandom, col);
      end else begin
        w = wide ? $urandom : $urandom_range(1, 32);
        h = wide ? $urandom : $urandom_range(1, 32);
        ox = wide ? $urandom : $urandom_range(0, 40);
        oy = wide ? $urandom : $urandom_range(0, 40);
        if ($urandom_range(0, 3) == 0) col = 0;
        queue_cmd(MODE_SPRITE, near(fx - 16, 24), near(fy - 16, 24), w, h, ox, oy, col);
      end
    end

    while (pending_cmds.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_colors.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (expected_colors.size() != 0) begin
      $display("%0d results never arrived", expected_colors.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
